// File: sv/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg: shared types and codes for the delta list timer queue
// Commands, status codes and the controller/datapath command struct.
// ----------------------------------------------------------------------------
`default_nettype none
package dltq_pkg;
   localparam logic [1:0] CMD_ADD  = 2'd0;
   localparam logic [1:0] CMD_DEL  = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;

   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_EXPIRED  = 3'd1;
   localparam logic [2:0] ST_NONE     = 3'd2;
   localparam logic [2:0] ST_BAD_ADD  = 3'd3;
   localparam logic [2:0] ST_IDLE_DEL = 3'd4;

   // Datapath operations issued by the controller.
   localparam logic [3:0] OP_NOP       = 4'd0;
   localparam logic [3:0] OP_LOAD      = 4'd1;  // capture request, cur := head
   localparam logic [3:0] OP_ADD_STEP  = 4'd2;  // one walk step of an add
   localparam logic [3:0] OP_ADD_LINK  = 4'd3;  // write the new node in
   localparam logic [3:0] OP_UNL_START = 4'd4;  // fold delta into successor
   localparam logic [3:0] OP_UNL_STEP  = 4'd5;  // search for predecessor
   localparam logic [3:0] OP_UNL_FIN   = 4'd6;  // relink predecessor
   localparam logic [3:0] OP_TICK_DEC  = 4'd7;  // decrement the head
   localparam logic [3:0] OP_TICK_HEAD = 4'd8;  // target := head for unlink

   typedef struct packed {
      logic [3:0] op;
   } ctl_type;

   typedef struct packed {
      logic       add_bad;    // captured add is illegal
      logic       del_idle;   // captured delete targets an idle slot
      logic       walk_done;  // add walk or predecessor search has ended
      logic       head_zero;  // list nonempty and head delta is zero
   } sts_type;
endpackage
`default_nettype wire

// File: sv/dltq_datapath.sv
// ----------------------------------------------------------------------------
// dltq_datapath: list storage and walk registers
// Holds the delta list and performs one list step per controller operation.
// ----------------------------------------------------------------------------
`default_nettype none
module dltq_datapath #(
   parameter int NUM_TIMERS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [3:0]        id,
   input  wire logic [31:0]       expiry,
   input  dltq_pkg::ctl_type      ctl,
   output dltq_pkg::sts_type      sts,
   output logic [3:0]             target_id
);
   import dltq_pkg::*;
   localparam int SW = (NUM_TIMERS > 16) ? $clog2(NUM_TIMERS) : 4;
   localparam int IW = $clog2(NUM_TIMERS);
   // Slot count held one bit wider so that a full power of two fits.
   localparam logic [SW:0] SLOT_LIMIT = (SW+1)'(NUM_TIMERS);

   logic [31:0]   delta_ff [NUM_TIMERS];
   logic [SW-1:0] next_ff  [NUM_TIMERS];
   logic          hasn_ff  [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] queued_ff;
   logic [SW-1:0] head_ff;
   logic          nonempty_ff;

   logic [SW-1:0] id_ff, cur_ff, prev_ff, succ_ff;
   logic [31:0]   exp_ff;
   logic          have_cur_ff, have_prev_ff, have_succ_ff, done_ff, found_ff;

   logic          slot_ok;
   logic [31:0]   cur_delta;
   logic          cur_link;
   logic [SW-1:0] cur_next;

   assign slot_ok   = {1'b0, id_ff} < SLOT_LIMIT;
   assign cur_delta = delta_ff[cur_ff[IW-1:0]];
   assign cur_link  = hasn_ff[cur_ff[IW-1:0]];
   assign cur_next  = next_ff[cur_ff[IW-1:0]];

   assign sts.add_bad   = !slot_ok || exp_ff == 32'd0 || queued_ff[id_ff[IW-1:0]];
   assign sts.del_idle  = !slot_ok || !queued_ff[id_ff[IW-1:0]];
   assign sts.walk_done = done_ff;
   assign sts.head_zero = nonempty_ff && delta_ff[head_ff[IW-1:0]] == 32'd0;
   assign target_id     = id_ff[3:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         queued_ff   <= '0;
         head_ff     <= '0;
         nonempty_ff <= 1'b0;
      end else begin
         case (ctl.op)
            OP_LOAD: begin
               id_ff       <= SW'(id);
               exp_ff      <= expiry;
               cur_ff      <= head_ff;
               have_cur_ff <= nonempty_ff;
               have_prev_ff <= 1'b0;
               done_ff     <= !nonempty_ff;
            end
            OP_ADD_STEP: begin
               if (!have_cur_ff) begin
                  done_ff <= 1'b1;
               end else if (exp_ff < cur_delta) begin
                  delta_ff[cur_ff[IW-1:0]] <= cur_delta - exp_ff;
                  done_ff <= 1'b1;
               end else begin
                  exp_ff       <= exp_ff - cur_delta;
                  prev_ff      <= cur_ff;
                  have_prev_ff <= 1'b1;
                  have_cur_ff  <= cur_link;
                  cur_ff       <= cur_next;
                  done_ff      <= !cur_link;
               end
            end
            OP_ADD_LINK: begin
               delta_ff[id_ff[IW-1:0]] <= exp_ff;
               hasn_ff[id_ff[IW-1:0]]  <= have_cur_ff;
               next_ff[id_ff[IW-1:0]]  <= cur_ff;
               if (have_prev_ff) begin
                  hasn_ff[prev_ff[IW-1:0]] <= 1'b1;
                  next_ff[prev_ff[IW-1:0]] <= id_ff;
               end else begin
                  head_ff     <= id_ff;
                  nonempty_ff <= 1'b1;
               end
               queued_ff[id_ff[IW-1:0]] <= 1'b1;
            end
            OP_TICK_DEC: begin
               if (nonempty_ff && delta_ff[head_ff[IW-1:0]] != 32'd0)
                  delta_ff[head_ff[IW-1:0]] <= delta_ff[head_ff[IW-1:0]] - 32'd1;
            end
            OP_TICK_HEAD: begin
               id_ff <= head_ff;
            end
            OP_UNL_START: begin
               have_succ_ff <= hasn_ff[id_ff[IW-1:0]];
               succ_ff      <= next_ff[id_ff[IW-1:0]];
               found_ff     <= 1'b0;
               if (hasn_ff[id_ff[IW-1:0]])
                  delta_ff[next_ff[id_ff[IW-1:0]][IW-1:0]] <=
                     delta_ff[next_ff[id_ff[IW-1:0]][IW-1:0]] + delta_ff[id_ff[IW-1:0]];
               cur_ff  <= head_ff;
               done_ff <= 1'b0;
               if (nonempty_ff && head_ff == id_ff) begin
                  head_ff     <= next_ff[id_ff[IW-1:0]];
                  nonempty_ff <= hasn_ff[id_ff[IW-1:0]];
                  done_ff     <= 1'b1;
               end else if (!nonempty_ff) begin
                  done_ff <= 1'b1;
               end
            end
            OP_UNL_STEP: begin
               prev_ff <= cur_ff;
               if (!cur_link) begin
                  done_ff <= 1'b1;
               end else begin
                  cur_ff <= cur_next;
                  if (cur_next == id_ff) begin
                     found_ff <= 1'b1;
                     done_ff  <= 1'b1;
                  end
               end
            end
            OP_UNL_FIN: begin
               if (found_ff) begin
                  hasn_ff[prev_ff[IW-1:0]] <= have_succ_ff;
                  next_ff[prev_ff[IW-1:0]] <= succ_ff;
               end
               hasn_ff[id_ff[IW-1:0]]   <= 1'b0;
               queued_ff[id_ff[IW-1:0]] <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   // The head is always a queued slot while the list is nonempty.
   a_head_queued: assert property (@(posedge clock) disable iff (reset)
      nonempty_ff |-> queued_ff[head_ff[IW-1:0]])
      else $error("head slot not queued");
   // An empty list holds at most the slot that is still being unlinked.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      !nonempty_ff |-> $countones(queued_ff) <= 1)
      else $error("queued slot with empty list");
   // Linking a new node always leaves the list nonempty.
   a_link: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_ADD_LINK |=> nonempty_ff)
      else $error("list empty after add");
endmodule
`default_nettype wire

// File: sv/dltq_control.sv
// ----------------------------------------------------------------------------
// dltq_control: sequencer for the delta list timer queue
// Accepts one item, steps the datapath and produces the result items.
// ----------------------------------------------------------------------------
`default_nettype none
module dltq_control (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire logic [1:0]    in_cmd,
   output dltq_pkg::ctl_type  ctl,
   input  dltq_pkg::sts_type  sts,
   input  wire logic [3:0]    target_id,
   output logic               out_valid,
   input  wire logic          out_ready,
   output logic [2:0]         out_status,
   output logic [3:0]         out_id,
   output logic               out_last
);
   import dltq_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_ADD    = 4'd2;
   localparam logic [3:0] S_LINK   = 4'd3;
   localparam logic [3:0] S_ULST   = 4'd4;
   localparam logic [3:0] S_ULWALK = 4'd5;
   localparam logic [3:0] S_ULFIN  = 4'd6;
   localparam logic [3:0] S_TCHK   = 4'd7;
   localparam logic [3:0] S_OUT    = 4'd8;
   localparam logic [3:0] S_TDEC   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [1:0] cmd_ff, cmd_in;
   logic       tick_ff, tick_in;     // unlink belongs to a tick
   logic       any_ff, any_in;       // tick has expired a timer
   logic       pend_ff, pend_in;     // expired result waiting for its last flag
   logic [3:0] pid_ff, pid_in;
   logic [2:0] rs_ff, rs_in;         // status of the single result still to send
   logic       ov_ff, ov_in;
   logic [2:0] os_ff, os_in;
   logic [3:0] oi_ff, oi_in;
   logic       ol_ff, ol_in;

   logic       free;
   assign free       = !ov_ff || out_ready;
   assign out_valid  = ov_ff;
   assign out_status = os_ff;
   assign out_id     = oi_ff;
   assign out_last   = ol_ff;
   assign in_ready   = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; tick_in = tick_ff; any_in = any_ff;
      pend_in = pend_ff; pid_in = pid_ff; rs_in = rs_ff;
      ov_in = ov_ff && !out_ready; os_in = os_ff; oi_in = oi_ff; ol_in = ol_ff;
      ctl.op = OP_NOP;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               ctl.op = OP_LOAD; cmd_in = in_cmd; state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (cmd_ff == CMD_ADD) begin
               if (sts.add_bad) begin
                  rs_in = ST_BAD_ADD; state_in = S_OUT;
               end else begin
                  state_in = S_ADD;
               end
            end else if (cmd_ff == CMD_DEL) begin
               if (sts.del_idle) begin
                  rs_in = ST_IDLE_DEL; state_in = S_OUT;
               end else begin
                  tick_in = 1'b0; state_in = S_ULST;
               end
            end else if (cmd_ff == CMD_TICK) begin
               any_in = 1'b0; pend_in = 1'b0; state_in = S_TDEC;
            end else begin
               rs_in = ST_DONE; state_in = S_OUT;
            end
         end
         S_ADD: begin
            if (sts.walk_done) begin
               state_in = S_LINK;
            end else begin
               ctl.op = OP_ADD_STEP;
            end
         end
         S_LINK: begin
            ctl.op = OP_ADD_LINK; rs_in = ST_DONE; state_in = S_OUT;
         end
         S_TDEC: begin
            ctl.op = OP_TICK_DEC; state_in = S_TCHK;
         end
         S_TCHK: begin
            if (sts.head_zero) begin
               if (!pend_ff || free) begin
                  if (pend_ff) begin
                     ov_in = 1'b1; os_in = ST_EXPIRED; oi_in = pid_ff; ol_in = 1'b0;
                  end
                  ctl.op = OP_TICK_HEAD; tick_in = 1'b1; state_in = S_ULST;
               end
            end else if (free) begin
               ov_in = 1'b1; ol_in = 1'b1;
               os_in = any_ff ? ST_EXPIRED : ST_NONE;
               oi_in = any_ff ? pid_ff : 4'd0;
               state_in = S_IDLE;
            end
         end
         S_ULST: begin
            ctl.op = OP_UNL_START; state_in = S_ULWALK;
         end
         S_ULWALK: begin
            if (sts.walk_done) begin
               state_in = S_ULFIN;
            end else begin
               ctl.op = OP_UNL_STEP;
            end
         end
         S_ULFIN: begin
            ctl.op = OP_UNL_FIN;
            if (tick_ff) begin
               any_in = 1'b1; pend_in = 1'b1; pid_in = target_id; state_in = S_TCHK;
            end else begin
               rs_in = ST_DONE; state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (free) begin
               ov_in = 1'b1; os_in = rs_ff; oi_in = 4'd0; ol_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff    <= 1'b0;
         pend_ff  <= 1'b0;
         any_ff   <= 1'b0;
         tick_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
         pend_ff  <= pend_in;
         any_ff   <= any_in;
         tick_ff  <= tick_in;
      end
      cmd_ff <= cmd_in;
      pid_ff <= pid_in;
      rs_ff  <= rs_in;
      os_ff  <= os_in;
      oi_ff  <= oi_in;
      ol_ff  <= ol_in;
   end

   // A stalled result holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !out_ready |=> ov_ff && $stable(os_ff) && $stable(oi_ff))
      else $error("result changed while stalled");
   // Items are only taken while no work is in progress.
   a_accept: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> state_ff == S_DECODE)
      else $error("accept did not start decode");
   // A tick result without expiry always carries id zero.
   a_none: assert property (@(posedge clock) disable iff (reset)
      ov_ff && os_ff == ST_NONE |-> oi_ff == 4'd0 && ol_ff)
      else $error("bad no-expiry result");
endmodule
`default_nettype wire

// File: sv/delta_list_timer_queue.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue: timer slots kept as an ordered delta list
//
// The req_ channel takes one command item (add, delete, tick). The rsp_
// channel returns one item per command, or one per expired timer on a tick,
// with rsp_tlast on the final one. An add walks the list one entry per
// cycle; a delete walks to the predecessor in the same way. A tick
// decrements the head, then does one unlink walk per expired timer. One
// item is in work at a time: req_tready is high only while the sequencer
// is idle. The result sits in an output register; while the receiver
// stalls the sequencer waits on it.
// Reset clears the queued flags and the head; link and delta storage hold
// nothing useful until written and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module delta_list_timer_queue #(
   parameter int NUM_TIMERS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // timer_id[3:0], new_expiry[35:4], pad
   input  wire logic [1:0]  req_tuser,   // command[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // status[2:0], expired_id[6:3], pad
   output logic             rsp_tlast
);
   import dltq_pkg::*;

   ctl_type    ctl;
   sts_type    sts;
   logic [3:0] target_id;
   logic [2:0] status;
   logic [3:0] expired_id;

   dltq_datapath #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
      .clock(clock), .reset(reset), .id(req_tdata[3:0]), .expiry(req_tdata[35:4]),
      .ctl(ctl), .sts(sts), .target_id(target_id)
   );

   dltq_control u_ctl (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_cmd(req_tuser), .ctl(ctl), .sts(sts), .target_id(target_id),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_status(status),
      .out_id(expired_id), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {1'b0, expired_id, status};
endmodule
`default_nettype wire
